/* hw/rtl/mcf_pkg.sv */
// Shared types, frame constants and CRC-16 byte update for the motor command framer.
`default_nettype none

package mcf_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] frame_idx_t;
  typedef logic [15:0] crc_t;

  // Frame layout
  localparam byte_t      SOF_BYTE     = 8'hFF;
  localparam byte_t      LEN_BYTE     = 8'h07;
  localparam byte_t      PAD_BYTE     = 8'h00;
  localparam byte_t      FLAGS_RESET  = 8'h50;

  localparam frame_idx_t IDX_SOF      = 4'd0;
  localparam frame_idx_t IDX_LEN      = 4'd1;
  localparam frame_idx_t IDX_SPEED_L  = 4'd2;
  localparam frame_idx_t IDX_PAD_L    = 4'd3;
  localparam frame_idx_t IDX_SPEED_R  = 4'd4;
  localparam frame_idx_t IDX_PAD_R    = 4'd5;
  localparam frame_idx_t IDX_FLAGS    = 4'd6;
  localparam frame_idx_t IDX_CRC_LO   = 4'd7;
  localparam frame_idx_t IDX_CRC_HI   = 4'd8;

  // CRC-16, reflected form
  localparam crc_t CRC_INIT = 16'hFFFF;
  localparam crc_t CRC_POLY = 16'hA001;

  // Fold one byte into the running CRC, LSB first
  function automatic crc_t crc_update(input crc_t crc_in, input byte_t data);
    crc_t c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/motor_command_frame_crc16.sv */
// Top level: turns each speed command into a nine-byte motor frame with a CRC-16 trailer.
`default_nettype none

// Each accepted speed beat produces nine output beats, one per cycle while the
// output is not stalled: 0xFF, 0x07, speed, 0x00, speed, 0x00, direction flags,
// CRC low, CRC high (CRC-16/MODBUS over bytes 1 to 6). The next command is taken
// in the cycle the last byte of the current frame is loaded into the output
// register, so frames stream back to back. The CRC is accumulated one byte per
// cycle while the output is not stalled, as bytes 1 to 6 go out. An accepted
// command is first registered in the generator state and its first byte then
// passes through the output register. frame_last marks byte 8.
// Write direction_flags only while no frame is in progress.
module motor_command_frame_crc16 (
  input  wire                 clk,
  input  wire                 rst_n,
  // Command input
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [7:0]          in_speed,
  // Frame byte output
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [7:0]          out_frame_byte,
  output logic [3:0]          out_byte_index,
  output logic                out_frame_last,
  // Direction flag register
  input  wire                 cfg_wr_en,
  input  wire  [7:0]          cfg_wr_data
);

  import mcf_pkg::*;

  // Generator state
  logic       active_r, active_nxt;
  frame_idx_t idx_r, idx_nxt;
  byte_t      speed_r, speed_nxt;
  crc_t       crc_r, crc_nxt;
  byte_t      flags_r;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  byte_t      out_byte_r;
  frame_idx_t out_idx_r;
  logic       out_last_r;

  logic       advance;
  logic       in_take;
  byte_t      cur_byte;

  // Move a byte when the output register is empty or draining
  assign advance  = active_r && (!out_valid_r || !out_stall);
  assign in_stall = active_r && !(advance && (idx_r == IDX_CRC_HI));
  assign in_take  = in_valid && !in_stall;

  // Select the byte for the current frame position
  always_comb begin
    case (idx_r) inside
      IDX_SOF:                 cur_byte = SOF_BYTE;
      IDX_LEN:                 cur_byte = LEN_BYTE;
      IDX_SPEED_L, IDX_SPEED_R: cur_byte = speed_r;
      IDX_PAD_L, IDX_PAD_R:    cur_byte = PAD_BYTE;
      IDX_FLAGS:               cur_byte = flags_r;
      IDX_CRC_LO:              cur_byte = crc_r[7:0];
      IDX_CRC_HI:              cur_byte = crc_r[15:8];
      default:                 cur_byte = PAD_BYTE;
    endcase
  end

  // Advance position, accumulate CRC, drop output valid once drained, load a new command
  always_comb begin
    active_nxt    = active_r;
    idx_nxt       = idx_r;
    speed_nxt     = speed_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;

    if (advance) begin
      idx_nxt       = idx_r + 4'd1;
      out_valid_nxt = 1'b1;
      if ((idx_r >= IDX_LEN) && (idx_r <= IDX_FLAGS)) begin
        crc_nxt = crc_update(crc_r, cur_byte);
      end
      if (idx_r == IDX_CRC_HI) begin
        active_nxt = 1'b0;
      end
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (in_take) begin
      active_nxt = 1'b1;
      idx_nxt    = IDX_SOF;
      speed_nxt  = in_speed;
      crc_nxt    = CRC_INIT;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= IDX_SOF;
      out_valid_r <= 1'b0;
      flags_r     <= FLAGS_RESET;
    end else begin
      active_r    <= active_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        flags_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    speed_r <= speed_nxt;
    crc_r   <= crc_nxt;
    if (advance) begin
      out_byte_r <= cur_byte;
      out_idx_r  <= idx_r;
      out_last_r <= (idx_r == IDX_CRC_HI);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_byte_index = out_idx_r;
  assign out_frame_last = out_last_r;

  // Checks
  a_last_on_crc_hi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_last_r == (out_idx_r == IDX_CRC_HI)))
    else $error("frame_last does not match byte index");

  a_sof_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_idx_r == IDX_SOF)) |-> (out_byte_r == SOF_BYTE))
    else $error("frame does not start with SOF byte");

  a_take_starts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> (active_r && (idx_r == IDX_SOF) && (crc_r == CRC_INIT)))
    else $error("accepted command did not start a frame");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (idx_r <= IDX_CRC_HI))
    else $error("frame position out of range");

  a_no_take_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && (idx_r != IDX_CRC_HI)) |-> !in_take)
    else $error("command taken in the middle of a frame");

endmodule

`default_nettype wire
